### rtl/escaped_frame_encoder_sum_macros.svh
// ----------------------------------------------------------------------------
// escaped frame encoder assertion macros
// concurrent checks on clk with rst_n low masking the check
// ----------------------------------------------------------------------------
`ifndef ESCAPED_FRAME_ENCODER_SUM_MACROS_SVH
`define ESCAPED_FRAME_ENCODER_SUM_MACROS_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define EFES_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("efes check failed");
// condition never holds
`define EFES_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("efes check failed");
`else
`define EFES_ASSERT_IMPLIES(lbl, ante, cons)
`define EFES_ASSERT_NEVER(lbl, cond)
`endif
`endif

### rtl/efes_pkg.sv
// ----------------------------------------------------------------------------
// efes_pkg
// shared constants and types of the escaped frame encoder
// ----------------------------------------------------------------------------
package efes_pkg;

    localparam logic [7:0] MARK_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_FLIP  = 8'h20;
    localparam logic [7:0] CHK_BASE  = 8'hFF;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // one classified item: which frame parts it emits and their raw bytes
    typedef struct packed {
        logic       has_open;
        logic       has_data;
        logic       has_close;
        logic [7:0] len_byte;
        logic [7:0] type_byte;
        logic [7:0] data_byte;
        logic [7:0] chk_byte;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

### rtl/efes_front.sv
// ----------------------------------------------------------------------------
// efes_front
// accepts input transfers, keeps frame state and the running sum, and
// writes one classified entry per item that emits bytes
// ----------------------------------------------------------------------------
module efes_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                first_of_frame,
    input  logic                last_of_frame,
    input  logic                carries_data,
    input  logic [7:0]          frame_type,
    input  logic [7:0]          payload_len,
    input  logic [7:0]          data_byte,
    input  efes_pkg::q_status_t q_status,
    output logic                q_push,
    output efes_pkg::entry_t    q_entry
);

    logic [15:0] running_sum_reg;
    logic [15:0] running_sum_next;
    logic        inside_frame_reg;
    logic        inside_frame_next;

    logic        accept;
    logic        emits;
    logic [7:0]  len_byte;
    logic [15:0] base_sum;
    logic [15:0] new_sum;
    logic [8:0]  folded;

    assign in_stall = q_status.full;
    assign accept   = in_valid && !q_status.full;
    assign emits    = first_of_frame
                   || (inside_frame_reg && (carries_data || last_of_frame));
    assign q_push   = accept && emits;

    assign len_byte = payload_len + 8'd1;
    assign base_sum = first_of_frame
                    ? ({8'd0, len_byte} + {8'd0, frame_type})
                    : running_sum_reg;
    assign new_sum  = base_sum + (carries_data ? {8'd0, data_byte} : 16'd0);
    // fold high byte back in, checksum is base minus folded sum mod 256
    assign folded   = {1'b0, new_sum[7:0]} + {1'b0, new_sum[15:8]};

    always_comb
    begin
        q_entry.has_open  = first_of_frame;
        q_entry.has_data  = carries_data;
        q_entry.has_close = last_of_frame;
        q_entry.len_byte  = len_byte;
        q_entry.type_byte = frame_type;
        q_entry.data_byte = data_byte;
        q_entry.chk_byte  = efes_pkg::CHK_BASE - folded[7:0];
    end

    always_comb
    begin
        running_sum_next  = running_sum_reg;
        inside_frame_next = inside_frame_reg;
        if (accept && (first_of_frame || inside_frame_reg))
        begin
            if (last_of_frame)
            begin
                running_sum_next  = 16'd0;
                inside_frame_next = 1'b0;
            end
            else
            begin
                running_sum_next  = new_sum;
                inside_frame_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_sum_reg  <= 16'd0;
            inside_frame_reg <= 1'b0;
        end
        else
        begin
            running_sum_reg  <= running_sum_next;
            inside_frame_reg <= inside_frame_next;
        end
    end

endmodule

### rtl/efes_queue.sv
// ----------------------------------------------------------------------------
// efes_queue
// short first-in first-out queue of classified entries
// ----------------------------------------------------------------------------
module efes_queue
#(
    parameter int DEPTH = efes_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  efes_pkg::entry_t    push_entry,
    input  logic                pop,
    output efes_pkg::entry_t    head_entry,
    output efes_pkg::q_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    efes_pkg::entry_t slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    logic do_push;
    logic do_pop;

    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_entry   = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/efes_back.sv
// ----------------------------------------------------------------------------
// efes_back
// walks the head entry part by part, escapes bytes and drives the
// registered output channel
// ----------------------------------------------------------------------------
module efes_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  efes_pkg::entry_t    head_entry,
    input  efes_pkg::q_status_t q_status,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          line_byte,
    output logic                run_last,
    output logic                frame_done
);

    typedef enum logic [2:0] {
        PH_START,
        PH_OPEN,
        PH_LEN,
        PH_TYPE,
        PH_DATA,
        PH_CHK,
        PH_CLOSE,
        PH_END
    } phase_t;

    phase_t     phase_reg;
    phase_t     phase_next;
    phase_t     cur_phase;
    phase_t     nxt_phase;
    logic       esc_reg;
    logic       esc_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] line_byte_reg;
    logic [7:0] line_byte_next;
    logic       run_last_reg;
    logic       run_last_next;
    logic       frame_done_reg;
    logic       frame_done_next;

    logic       advance;
    logic [7:0] raw_byte;
    logic       needs_esc;

    assign advance = !q_status.empty && (!out_valid_reg || !out_stall);

    always_comb
    begin
        cur_phase = phase_reg;
        if (phase_reg == PH_START)
        begin
            if (head_entry.has_open)
            begin
                cur_phase = PH_OPEN;
            end
            else if (head_entry.has_data)
            begin
                cur_phase = PH_DATA;
            end
            else
            begin
                cur_phase = PH_CHK;
            end
        end
    end

    always_comb
    begin
        case (cur_phase)
            PH_OPEN:  nxt_phase = PH_LEN;
            PH_LEN:   nxt_phase = PH_TYPE;
            PH_TYPE:  nxt_phase = head_entry.has_data ? PH_DATA
                                : (head_entry.has_close ? PH_CHK : PH_END);
            PH_DATA:  nxt_phase = head_entry.has_close ? PH_CHK : PH_END;
            PH_CHK:   nxt_phase = PH_CLOSE;
            default:  nxt_phase = PH_END;
        endcase
    end

    always_comb
    begin
        case (cur_phase)
            PH_LEN:   raw_byte = head_entry.len_byte;
            PH_TYPE:  raw_byte = head_entry.type_byte;
            PH_DATA:  raw_byte = head_entry.data_byte;
            PH_CHK:   raw_byte = head_entry.chk_byte;
            default:  raw_byte = efes_pkg::MARK_BYTE;
        endcase
    end

    // markers go out plain, every other part is stuffed
    assign needs_esc = !(cur_phase inside {PH_OPEN, PH_CLOSE})
                    && ((raw_byte == efes_pkg::MARK_BYTE)
                     || (raw_byte == efes_pkg::ESC_BYTE));

    always_comb
    begin
        phase_next      = phase_reg;
        esc_next        = esc_reg;
        pop             = 1'b0;
        out_valid_next  = out_valid_reg && out_stall;
        line_byte_next  = line_byte_reg;
        run_last_next   = run_last_reg;
        frame_done_next = frame_done_reg;
        if (advance)
        begin
            out_valid_next  = 1'b1;
            frame_done_next = 1'b0;
            if (needs_esc && !esc_reg)
            begin
                line_byte_next = efes_pkg::ESC_BYTE;
                run_last_next  = 1'b0;
                esc_next       = 1'b1;
                phase_next     = cur_phase;
            end
            else
            begin
                line_byte_next = esc_reg ? (raw_byte ^ efes_pkg::ESC_FLIP) : raw_byte;
                esc_next       = 1'b0;
                run_last_next  = (nxt_phase == PH_END);
                if (nxt_phase == PH_END)
                begin
                    pop        = 1'b1;
                    phase_next = PH_START;
                end
                else
                begin
                    phase_next = nxt_phase;
                end
                frame_done_next = (cur_phase == PH_CLOSE);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_START;
            esc_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            line_byte_reg  <= 8'd0;
            run_last_reg   <= 1'b0;
            frame_done_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            esc_reg        <= esc_next;
            out_valid_reg  <= out_valid_next;
            line_byte_reg  <= line_byte_next;
            run_last_reg   <= run_last_next;
            frame_done_reg <= frame_done_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign line_byte  = line_byte_reg;
    assign run_last   = run_last_reg;
    assign frame_done = frame_done_reg;

endmodule

### rtl/escaped_frame_encoder_sum.sv
// ----------------------------------------------------------------------------
// escaped_frame_encoder_sum
// byte-stuffed serial frame encoder with folded additive checksum
// ----------------------------------------------------------------------------
// One input transfer brings at most one payload byte; the first transfer of a
// frame also brings type and length. Each frame goes out on the line as an
// opening 0x7E, the length (payload_len plus one), the type, the data bytes,
// the checksum and a closing 0x7E, one byte per output transfer. Every byte
// but the markers is stuffed: 0x7E or 0x7D leaves as 0x7D then byte ^ 0x20.
// The checksum is 0xFF minus the folded 16-bit sum of length, type and data.
// An item without first_of_frame while no frame is open is dropped. The
// output side sends one byte per clock while the queue holds an entry and
// out_stall is low. An item emits one or two bytes for a plain data byte
// and up to ten for a one-byte frame. The back-end sequencer walks one
// output byte per cycle when not stalled. The front end classifies items
// combinationally, keeps the running sum registered, and takes a new item
// every clock while the queue (QUEUE_DEPTH entries) has room, so input and
// output stall independently. After reset the block is ready at once.
// ----------------------------------------------------------------------------
`include "escaped_frame_encoder_sum_macros.svh"

module escaped_frame_encoder_sum
#(
    parameter int QUEUE_DEPTH = efes_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    // input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       first_of_frame,
    input  logic       last_of_frame,
    input  logic       carries_data,
    input  logic [7:0] frame_type,
    input  logic [7:0] payload_len,
    input  logic [7:0] data_byte,
    // output channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] line_byte,
    output logic       run_last,
    output logic       frame_done
);

    efes_pkg::q_status_t q_status;
    efes_pkg::entry_t    q_entry;
    efes_pkg::entry_t    head_entry;
    logic                q_push;
    logic                q_pop;

    // front end: frame state, running sum and checksum, one entry per item that emits bytes
    efes_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .first_of_frame (first_of_frame),
        .last_of_frame  (last_of_frame),
        .carries_data   (carries_data),
        .frame_type     (frame_type),
        .payload_len    (payload_len),
        .data_byte      (data_byte),
        .q_status       (q_status),
        .q_push         (q_push),
        .q_entry        (q_entry)
    );

    // decouples item acceptance from byte emission
    efes_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head_entry (head_entry),
        .status     (q_status)
    );

    // back end: escape sequencer and output register
    efes_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_entry (head_entry),
        .q_status   (q_status),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .line_byte  (line_byte),
        .run_last   (run_last),
        .frame_done (frame_done)
    );

    // closing marker is always the last byte of its item
    `EFES_ASSERT_IMPLIES(a_done_is_mark, out_valid && frame_done, (line_byte == efes_pkg::MARK_BYTE) && run_last)
    // an opening marker is always followed by the length byte
    `EFES_ASSERT_IMPLIES(a_open_not_last, out_valid && (line_byte == efes_pkg::MARK_BYTE) && !frame_done, !run_last)
    // front never writes into a full queue
    `EFES_ASSERT_NEVER(a_no_push_full, q_push && q_status.full)
    // queue status stays consistent
    `EFES_ASSERT_NEVER(a_full_and_empty, q_status.full && q_status.empty)

endmodule

### tb/escaped_frame_encoder_sum_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// escaped_frame_encoder_sum_test
// self-checking bench for the byte-stuffed frame encoder
// ----------------------------------------------------------------------------
// A directed table walks the frame corners (ignored items, escaped bytes,
// length wrap, reopen while open, empty payload, split close), then random
// frames with mostly well-formed content, some broken frames and noise, and
// one long frame that wraps the 16-bit sum. A local encoder model predicts
// every line byte on each input transfer; a monitor compares each output
// transfer with the oldest prediction. Both sides idle at random, and the
// receiver once holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module escaped_frame_encoder_sum_test;

    localparam int HALF_PERIOD  = 4;
    localparam int IDLE_LIMIT   = 1000;  // cycles with no transfer on either side
    localparam int HOLD_CYCLES  = 150;   // one long receiver hold-off
    localparam int HOLD_AT      = 150;   // line bytes seen before that hold
    localparam int RANDOM_ITEMS = 410;
    localparam int LONG_ITEMS   = 270;   // enough near-0xff bytes to wrap the sum
    localparam int SETTLE       = 16;

    // one expected byte on the serial line
    typedef struct packed {
        logic [7:0] line;
        logic       last;
        logic       done;
    } line_beat_t;

    // one row of the directed table; typed rows also carry a hand-read
    // count of line bytes and the last byte of the item
    typedef struct packed {
        logic       is_first;
        logic       is_last;
        logic       has_data;
        logic [7:0] ftype;
        logic [7:0] plen;
        logic [7:0] dbyte;
        logic       typed;
        logic [3:0] typed_n;
        logic [7:0] typed_tail;
    } stim_row_t;

    localparam int DIR_ROWS = 20;

    stim_row_t dir_rows [DIR_ROWS] = '{
        // item outside a frame, dropped
        '{1'b0, 1'b0, 1'b1, 8'hAA, 8'h05, 8'hAA, 1'b1, 4'd0, 8'h00},
        // closing item outside a frame, dropped
        '{1'b0, 1'b1, 1'b1, 8'h55, 8'h10, 8'h7E, 1'b1, 4'd0, 8'h00},
        // open, empty length, zero type, no data: marker, 0x01, 0x00
        '{1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b1, 4'd3, 8'h00},
        // data equal to the marker is stuffed
        '{1'b0, 1'b0, 1'b1, 8'h00, 8'h00, 8'h7E, 1'b1, 4'd2, 8'h5E},
        // data equal to the escape is stuffed
        '{1'b0, 1'b0, 1'b1, 8'h00, 8'h00, 8'h7D, 1'b1, 4'd2, 8'h5D},
        // no data, no open, no close: nothing on the line
        '{1'b0, 1'b0, 1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b1, 4'd0, 8'h00},
        // plain zero data byte
        '{1'b0, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00, 1'b1, 4'd1, 8'h00},
        // all-ones data and close
        '{1'b0, 1'b1, 1'b1, 8'h00, 8'h00, 8'hFF, 1'b0, 4'd0, 8'h00},
        // length 255 wraps to 0x00, checksum comes out 0x00
        '{1'b1, 1'b1, 1'b1, 8'hFF, 8'hFF, 8'h00, 1'b1, 4'd6, 8'h7E},
        // length, type and data of a one-byte frame all escaped
        '{1'b1, 1'b1, 1'b1, 8'h7E, 8'h7C, 8'h7D, 1'b1, 4'd9, 8'h7E},
        // empty payload frame in one item
        '{1'b1, 1'b1, 1'b0, 8'h10, 8'h00, 8'h00, 1'b1, 4'd5, 8'h7E},
        // frame that gets abandoned
        '{1'b1, 1'b0, 1'b1, 8'h01, 8'h03, 8'h10, 1'b0, 4'd0, 8'h00},
        '{1'b0, 1'b0, 1'b1, 8'h00, 8'h00, 8'h20, 1'b0, 4'd0, 8'h00},
        // reopen while open clears the sum
        '{1'b1, 1'b0, 1'b1, 8'h7D, 8'h02, 8'h7E, 1'b0, 4'd0, 8'h00},
        '{1'b0, 1'b0, 1'b1, 8'h00, 8'h00, 8'h81, 1'b0, 4'd0, 8'h00},
        // close without data: checksum 0x7f, then the marker
        '{1'b0, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 1'b1, 4'd2, 8'h7E},
        // a second close finds no frame open
        '{1'b0, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 1'b1, 4'd0, 8'h00},
        // top legal length with data on the opening item
        '{1'b1, 1'b0, 1'b1, 8'h55, 8'hFE, 8'h7E, 1'b0, 4'd0, 8'h00},
        '{1'b0, 1'b1, 1'b1, 8'h00, 8'h00, 8'hC3, 1'b0, 4'd0, 8'h00},
        // length byte that needs stuffing
        '{1'b1, 1'b1, 1'b1, 8'h80, 8'h7D, 8'h01, 1'b0, 4'd0, 8'h00}
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       first_of_frame = 1'b0;
    logic       last_of_frame = 1'b0;
    logic       carries_data = 1'b0;
    logic [7:0] frame_type = 8'h00;
    logic [7:0] payload_len = 8'h00;
    logic [7:0] data_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b1;
    logic [7:0] line_byte;
    logic       run_last;
    logic       frame_done;

    // encoder model state
    logic [15:0] frame_sum = 16'h0000;
    logic        frame_open = 1'b0;
    line_beat_t  pending_bytes [$];
    int          beats_made;

    // what the last accepted item added, read back by the directed walk
    int          item_beats;
    logic [7:0]  item_tail;

    int  mismatches = 0;
    int  beats_seen = 0;
    int  idle_cycles = 0;
    bit  tx_burst = 1'b0;
    bit  rx_burst = 1'b0;
    bit  rx_held = 1'b0;

    escaped_frame_encoder_sum dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .first_of_frame (first_of_frame),
        .last_of_frame  (last_of_frame),
        .carries_data   (carries_data),
        .frame_type     (frame_type),
        .payload_len    (payload_len),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .line_byte      (line_byte),
        .run_last       (run_last),
        .frame_done     (frame_done)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------
    // encoder model
    // ------------------------------------------------------------------

    function automatic void push_beat(input logic [7:0] b, input logic done);
        line_beat_t beat;
        beat.line = b;
        beat.last = 1'b0;
        beat.done = done;
        pending_bytes.push_back(beat);
        beats_made++;
    endfunction

    // marker and escape go out as escape then byte ^ 0x20
    function automatic void push_stuffed(input logic [7:0] b);
        if (b == efes_pkg::MARK_BYTE || b == efes_pkg::ESC_BYTE)
        begin
            push_beat(efes_pkg::ESC_BYTE, 1'b0);
            push_beat(b ^ efes_pkg::ESC_FLIP, 1'b0);
        end
        else
        begin
            push_beat(b, 1'b0);
        end
    endfunction

    // high byte folded into low byte, then 0xff minus that, mod 256
    function automatic logic [7:0] fold_checksum(input logic [15:0] s);
        logic [8:0] folded;
        folded = {1'b0, s[7:0]} + {1'b0, s[15:8]};
        return efes_pkg::CHK_BASE - folded[7:0];
    endfunction

    function automatic void encode_item(input logic is_first, input logic is_last,
                                        input logic has_data, input logic [7:0] ftype,
                                        input logic [7:0] plen, input logic [7:0] dbyte);
        logic [7:0] len_byte;
        line_beat_t tail;
        beats_made = 0;
        if (is_first || frame_open)
        begin
            if (is_first)
            begin
                len_byte = plen + 8'd1;
                frame_open = 1'b1;
                push_beat(efes_pkg::MARK_BYTE, 1'b0);
                frame_sum = {8'h00, len_byte};
                push_stuffed(len_byte);
                frame_sum = frame_sum + {8'h00, ftype};
                push_stuffed(ftype);
            end
            if (has_data)
            begin
                frame_sum = frame_sum + {8'h00, dbyte};
                push_stuffed(dbyte);
            end
            if (is_last)
            begin
                push_stuffed(fold_checksum(frame_sum));
                push_beat(efes_pkg::MARK_BYTE, 1'b1);
                frame_sum = 16'h0000;
                frame_open = 1'b0;
            end
            if (beats_made > 0)
            begin
                tail = pending_bytes.pop_back();
                tail.last = 1'b1;
                pending_bytes.push_back(tail);
            end
        end
        item_beats = beats_made;
        if (beats_made > 0)
            item_tail = pending_bytes[pending_bytes.size() - 1].line;
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // one process sees both sides at each rising edge, so the prediction of
    // an input transfer is always in place before a same-edge output check
    always @(posedge clk)
    begin
        line_beat_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                encode_item(first_of_frame, last_of_frame, carries_data,
                            frame_type, payload_len, data_byte);
            if (out_valid && !out_stall)
            begin
                beats_seen++;
                if (pending_bytes.size() == 0)
                begin
                    report_mismatch("unexpected line byte", line_byte, 8'h00);
                end
                else
                begin
                    want = pending_bytes.pop_front();
                    if (line_byte != want.line)
                        report_mismatch("line_byte", line_byte, want.line);
                    if (run_last != want.last)
                        report_mismatch("run_last", {7'd0, run_last}, {7'd0, want.last});
                    if (frame_done != want.done)
                        report_mismatch("frame_done", {7'd0, frame_done},
                                        {7'd0, want.done});
                end
            end
        end
    end

    // watchdog: a long run of cycles with no transfer at all ends the run
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[escaped_frame_encoder_sum] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic int pick_gap(input bit burst);
        return burst ? 0 : $urandom_range(0, 9);
    endfunction

    // bias toward the two bytes that need stuffing
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return efes_pkg::MARK_BYTE;
            1: return efes_pkg::ESC_BYTE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // entered and left at a falling edge; valid stays up into the next
    // item when no gap is drawn
    task automatic send_item(input logic is_first, input logic is_last,
                             input logic has_data, input logic [7:0] ftype,
                             input logic [7:0] plen, input logic [7:0] dbyte);
        int gap;
        if ($urandom_range(0, 39) == 0)
            tx_burst = !tx_burst;
        gap = pick_gap(tx_burst);
        repeat (gap)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        first_of_frame <= is_first;
        last_of_frame  <= is_last;
        carries_data   <= has_data;
        frame_type     <= ftype;
        payload_len    <= plen;
        data_byte      <= dbyte;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // sender pause until the line has caught up with every prediction
    task automatic drain();
        while (pending_bytes.size() != 0)
            @(negedge clk);
    endtask

    // one frame of random content; an open frame is left for the next
    // opening item to abandon, and the close may come as its own item
    task automatic send_frame(input int n_data, input bit closed, input bit split_close,
                              inout int sent);
        logic [7:0] ftype;
        logic [7:0] plen;
        int i;
        ftype = pick_byte();
        plen = ($urandom_range(0, 3) == 0) ? 8'(n_data) : 8'($urandom_range(0, 255));
        if (n_data == 0)
        begin
            send_item(1'b1, closed && !split_close, 1'b0, ftype, plen, 8'($urandom));
            sent++;
        end
        for (i = 0; i < n_data; i++)
        begin
            // an occasional empty item inside the frame
            if (i > 0 && $urandom_range(0, 9) == 0)
            begin
                send_item(1'b0, 1'b0, 1'b0, 8'($urandom), 8'($urandom), 8'($urandom));
                sent++;
            end
            send_item(i == 0, closed && !split_close && i == n_data - 1, 1'b1,
                      i == 0 ? ftype : 8'($urandom), i == 0 ? plen : 8'($urandom),
                      pick_byte());
            sent++;
        end
        if (closed && split_close)
        begin
            send_item(1'b0, 1'b1, 1'b0, 8'($urandom), 8'($urandom), 8'($urandom));
            sent++;
        end
    endtask

    // ------------------------------------------------------------------
    // receiver: random stall per byte, burst stretches, one long hold-off
    // ------------------------------------------------------------------
    initial
    begin
        int gap;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (!rx_held && beats_seen >= HOLD_AT)
            begin
                // hold off while the sender keeps offering, so the block
                // fills and stalls its input
                rx_held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if ($urandom_range(0, 39) == 0)
                rx_burst = !rx_burst;
            gap = pick_gap(rx_burst);
            repeat (gap)
            begin
                out_stall <= 1'b1;
                @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            @(negedge clk);
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int sent;
        int kind;
        int k;
        bit long_done;
        sent = 0;
        long_done = 1'b0;

        // reset held at the start, released at a falling edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table
        for (k = 0; k < DIR_ROWS; k++)
        begin
            send_item(dir_rows[k].is_first, dir_rows[k].is_last, dir_rows[k].has_data,
                      dir_rows[k].ftype, dir_rows[k].plen, dir_rows[k].dbyte);
            if (dir_rows[k].typed)
            begin
                if (item_beats != int'(dir_rows[k].typed_n))
                    report_mismatch("line byte count", 8'(item_beats),
                                    {4'd0, dir_rows[k].typed_n});
                else if (item_beats > 0 && item_tail != dir_rows[k].typed_tail)
                    report_mismatch("last line byte", item_tail, dir_rows[k].typed_tail);
            end
        end

        // let the line empty before the random part
        in_valid <= 1'b0;
        @(negedge clk);
        drain();

        // random part
        while (sent < RANDOM_ITEMS)
        begin
            if (!long_done && sent >= 60)
            begin
                // long frame of high bytes: the running sum wraps past 0xffff
                long_done = 1'b1;
                send_item(1'b1, 1'b0, 1'b1, pick_byte(), 8'hFE, 8'hFF);
                sent++;
                for (k = 1; k < LONG_ITEMS; k++)
                begin
                    send_item(1'b0, k == LONG_ITEMS - 1, 1'b1, 8'($urandom),
                              8'($urandom), 8'($urandom_range(8'hF0, 8'hFF)));
                    sent++;
                end
            end
            else
            begin
                kind = $urandom_range(0, 99);
                if (kind < 80)
                    send_frame($urandom_range(0, 6), 1'b1, $urandom_range(0, 4) == 0, sent);
                else if (kind < 90)
                    // noise items without an opening flag, dropped unless a frame is still open
                    send_item(1'b0, 1'($urandom), 1'($urandom), 8'($urandom),
                              8'($urandom), 8'($urandom));
                else
                    send_frame($urandom_range(0, 4), 1'b0, 1'b0, sent);
            end
        end

        // close any frame left open so its tail is checked too
        send_item(1'b0, 1'b1, 1'b1, 8'h00, 8'h00, pick_byte());
        in_valid <= 1'b0;
        @(negedge clk);
        drain();
        repeat (SETTLE) @(posedge clk);

        if (pending_bytes.size() != 0)
            report_mismatch("line bytes never sent", 8'(pending_bytes.size()), 8'h00);
        if (mismatches == 0)
            $display("[escaped_frame_encoder_sum] OK");
        else
            $display("[escaped_frame_encoder_sum] ERROR");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/efes_pkg.sv
rtl/efes_front.sv
rtl/efes_queue.sv
rtl/efes_back.sv
rtl/escaped_frame_encoder_sum.sv
tb/escaped_frame_encoder_sum_test.sv
